>>> rtl/ipv6_csum_pkg.sv
// Shared types, constants and a helper function of the IPv6 pseudo-header checksum block.
package ipv6_csum_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_UPPER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_LOWER = 1'b1;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    // Sum widths: four 16-bit words fit in 18 bits, five in 19, the grand total in 22.
    localparam int QUAD_W  = 18;
    localparam int MISC_W  = 19;
    localparam int TOTAL_W = 22;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic        end_of_payload;
        logic [63:0] dest_addr_upper;
        logic [63:0] dest_addr_lower;
        logic [7:0]  upper_proto;
    } in_item_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic        length_overflow;
    } out_item_t;

    // One closed payload handed from the front end to the back end.
    typedef struct packed {
        logic [15:0]            run_sum;
        logic [15:0]            pad_word;
        logic [LENGTH_BITS-1:0] byte_count;
        logic                   overflow;
        logic [63:0]            dest_upper;
        logic [63:0]            dest_lower;
        logic [7:0]             upper_proto;
    } job_t;

    function automatic logic [QUAD_W-1:0] sum_quad(input logic [63:0] v);
        sum_quad = QUAD_W'(v[63:48]) + QUAD_W'(v[47:32])
                 + QUAD_W'(v[31:16]) + QUAD_W'(v[15:0]);
    endfunction

endpackage

>>> rtl/ipv6_pseudo_header_checksum.sv
// Top level of the IPv6 upper-layer checksum engine with pseudo-header.
//
// Usage: the input side looks like a queue. Each item carries one payload byte
// (or an empty-payload marker) together with the destination address and the
// next-header value, which are only looked at on the item marked end_of_payload.
// An item is accepted at a rising edge with push high and full low. Items that
// do not close a payload produce no result.
// The result side also looks like a queue: while empty is low, the oldest
// checksum and its length-overflow flag sit on the result port, and they are
// taken at a rising edge with pop high.
// The front end takes one item every cycle while full is low. A closing item
// reaches the result port through the hand-off queue, then the two pipeline
// stages of the pseudo-header adder, whose fold writes the result queue.
// Payloads may close back to back, one per cycle while full is low.
// When the receiver stalls, the two-entry result queue fills, the adder
// pipeline holds, the hand-off queue fills and full rises; bytes are then
// refused until pop drains a result. Reset clears the source address registers,
// the partial sum and byte count, and empties both queues. The user must write
// the source address through the configuration port only while no payload is
// in flight; the block itself does not enforce this.
module ipv6_pseudo_header_checksum (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [ipv6_csum_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ipv6_csum_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                     push,
    output logic                                     full,
    input  ipv6_csum_pkg::in_item_t                  request,
    output logic                                     empty,
    input  logic                                     pop,
    output ipv6_csum_pkg::out_item_t                 result
);

    logic [63:0]         source_upper_reg;
    logic [63:0]         source_lower_reg;
    logic                job_push;
    logic                job_pop;
    logic                job_empty;
    ipv6_csum_pkg::job_t job_in;
    ipv6_csum_pkg::job_t job_out;

    // Source address registers; both are ordinary 64-bit writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_upper_reg <= '0;
            source_lower_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ipv6_csum_pkg::CFG_SOURCE_UPPER: source_upper_reg <= cfg_data;
                ipv6_csum_pkg::CFG_SOURCE_LOWER: source_lower_reg <= cfg_data;
                default:                         source_upper_reg <= source_upper_reg;
            endcase
        end
    end

    // The front end accepts bytes and hands each closed payload to the queue.
    ipv6_csum_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .job_full (full),
        .job_push (job_push),
        .job      (job_in)
    );

    ipv6_csum_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_pop),
        .empty   (job_empty),
        .rd_data (job_out)
    );

    // The back end adds the pseudo-header and delivers the finished checksums.
    ipv6_csum_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_upper (source_upper_reg),
        .source_lower (source_lower_reg),
        .job_empty    (job_empty),
        .job          (job_out),
        .job_pop      (job_pop),
        .empty        (empty),
        .pop          (pop),
        .result       (result)
    );

endmodule

>>> rtl/ipv6_csum_front.sv
// Front end: pairs payload bytes into words, keeps the running sum and the byte count.
module ipv6_csum_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ipv6_csum_pkg::in_item_t request,
    input  logic                    job_full,
    output logic                    job_push,
    output ipv6_csum_pkg::job_t     job
);

    logic [15:0]                             run_sum_reg, run_sum_next;
    logic [7:0]                              held_reg, held_next;
    logic                                    pending_reg, pending_next;
    logic [ipv6_csum_pkg::LENGTH_BITS-1:0]   count_reg, count_next;
    logic                                    overflow_reg, overflow_next;
    logic [16:0]                             pair_sum;
    logic                                    accept;

    assign accept   = push && !job_full;
    assign pair_sum = 17'(run_sum_reg) + 17'({held_reg, request.payload_byte});

    always_comb
    begin
        run_sum_next  = run_sum_reg;
        held_next     = held_reg;
        pending_next  = pending_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (accept && request.byte_present)
        begin
            if (pending_reg)
            begin
                // End-around carry: the carry out of bit 15 wraps back into bit 0.
                run_sum_next = pair_sum[15:0] + 16'(pair_sum[16]);
                held_next    = 8'h00;
                pending_next = 1'b0;
            end
            else
            begin
                held_next    = request.payload_byte;
                pending_next = 1'b1;
            end
            if (count_reg == ipv6_csum_pkg::COUNT_MAX)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // The closing item carries the state as updated by its own byte.
    assign job_push         = accept && request.end_of_payload;
    assign job.run_sum      = run_sum_next;
    assign job.pad_word     = pending_next ? {held_next, 8'h00} : 16'h0000;
    assign job.byte_count   = count_next;
    assign job.overflow     = overflow_next;
    assign job.dest_upper   = request.dest_addr_upper;
    assign job.dest_lower   = request.dest_addr_lower;
    assign job.upper_proto  = request.upper_proto;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg  <= '0;
            held_reg     <= '0;
            pending_reg  <= 1'b0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (job_push)
        begin
            run_sum_reg  <= '0;
            held_reg     <= '0;
            pending_reg  <= 1'b0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            run_sum_reg  <= run_sum_next;
            held_reg     <= held_next;
            pending_reg  <= pending_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

>>> rtl/ipv6_csum_queue.sv
// Two-entry queue of closed payloads between the front end and the back end.
module ipv6_csum_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ipv6_csum_pkg::job_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                empty,
    output ipv6_csum_pkg::job_t rd_data
);

    ipv6_csum_pkg::job_t mem_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/ipv6_csum_back.sv
// Back end: adds the pseudo-header in a short pipeline, folds, and queues the results.
module ipv6_csum_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [63:0]                    source_upper,
    input  logic [63:0]                    source_lower,
    input  logic                           job_empty,
    input  ipv6_csum_pkg::job_t            job,
    output logic                           job_pop,
    output logic                           empty,
    input  logic                           pop,
    output ipv6_csum_pkg::out_item_t       result
);

    // Stage A: partial sums of four words each, plus the payload, length and next-header terms.
    logic                                  a_valid_reg;
    logic [ipv6_csum_pkg::QUAD_W-1:0]      a_src_u_reg, a_src_l_reg;
    logic [ipv6_csum_pkg::QUAD_W-1:0]      a_dst_u_reg, a_dst_l_reg;
    logic [ipv6_csum_pkg::MISC_W-1:0]      a_misc_reg;
    logic                                  a_ovf_reg;
    // Stage B: grand total before folding.
    logic                                  b_valid_reg;
    logic [ipv6_csum_pkg::TOTAL_W-1:0]     b_total_reg;
    logic                                  b_ovf_reg;

    logic [31:0]                           count_wide;
    logic [ipv6_csum_pkg::MISC_W-1:0]      misc_sum;
    logic [ipv6_csum_pkg::TOTAL_W-1:0]     total_sum;
    logic [16:0]                           fold1;
    logic [15:0]                           fold2;
    logic [15:0]                           inverted;
    ipv6_csum_pkg::out_item_t              c_item;
    logic                                  advance;

    // Result queue.
    ipv6_csum_pkg::out_item_t              out_mem_reg [2];
    logic                                  out_wr_ptr_reg;
    logic                                  out_rd_ptr_reg;
    logic [1:0]                            out_count_reg, out_count_next;
    logic                                  out_full;
    logic                                  out_wr, out_rd;

    assign out_full = (out_count_reg == 2'd2);
    assign advance  = !out_full;
    assign job_pop  = advance && !job_empty;

    assign count_wide = 32'(job.byte_count);
    assign misc_sum   = ipv6_csum_pkg::MISC_W'(job.run_sum)
                      + ipv6_csum_pkg::MISC_W'(job.pad_word)
                      + ipv6_csum_pkg::MISC_W'(count_wide[31:16])
                      + ipv6_csum_pkg::MISC_W'(count_wide[15:0])
                      + ipv6_csum_pkg::MISC_W'(job.upper_proto);

    assign total_sum = ipv6_csum_pkg::TOTAL_W'(a_src_u_reg)
                     + ipv6_csum_pkg::TOTAL_W'(a_src_l_reg)
                     + ipv6_csum_pkg::TOTAL_W'(a_dst_u_reg)
                     + ipv6_csum_pkg::TOTAL_W'(a_dst_l_reg)
                     + ipv6_csum_pkg::TOTAL_W'(a_misc_reg);

    // Two folds bring the total back to 16 bits; the second cannot carry again.
    assign fold1    = 17'(b_total_reg[15:0])
                    + 17'(b_total_reg[ipv6_csum_pkg::TOTAL_W-1:16]);
    assign fold2    = fold1[15:0] + 16'(fold1[16]);
    assign inverted = ~fold2;
    assign c_item.checksum        = (inverted == 16'h0000) ? 16'hFFFF : inverted;
    assign c_item.length_overflow = b_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_src_u_reg <= ipv6_csum_pkg::sum_quad(source_upper);
            a_src_l_reg <= ipv6_csum_pkg::sum_quad(source_lower);
            a_dst_u_reg <= ipv6_csum_pkg::sum_quad(job.dest_upper);
            a_dst_l_reg <= ipv6_csum_pkg::sum_quad(job.dest_lower);
            a_misc_reg  <= misc_sum;
            a_ovf_reg   <= job.overflow;
            b_total_reg <= total_sum;
            b_ovf_reg   <= a_ovf_reg;
        end
    end

    assign out_wr = advance && b_valid_reg;
    assign out_rd = pop && (out_count_reg != 2'd0);
    assign empty  = (out_count_reg == 2'd0);
    assign result = out_mem_reg[out_rd_ptr_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_wr && !out_rd)
        begin
            out_count_next = out_count_reg + 2'd1;
        end
        else if (out_rd && !out_wr)
        begin
            out_count_next = out_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_mem_reg[out_wr_ptr_reg] <= c_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                a_valid_reg <= !job_empty;
                b_valid_reg <= a_valid_reg;
            end
            if (out_wr)
            begin
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            end
            if (out_rd)
            begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
            out_count_reg <= out_count_next;
        end
    end

endmodule
